FILE: rtl/gpd_pkg.sv
// Package for the gated photon detector with dead time.
// Holds field widths, register indexes, reset values, class codes and item types.
// Depends on nothing.
`default_nettype none

package gpd_pkg;

  localparam int TIME_BITS      = 48;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 4;

  // Comparisons between times and 32-bit register values are made at this width.
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_WIDTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_TIME  = CFG_INDEX_BITS'(1);

  localparam logic [CFG_BITS-1:0] GATE_WIDTH_RESET = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] DEAD_TIME_RESET  = CFG_BITS'(0);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Position of a photon relative to its slot window.
  localparam int CLS_BITS = 2;
  localparam logic [CLS_BITS-1:0] CLS_EARLY  = 2'd0;
  localparam logic [CLS_BITS-1:0] CLS_INSIDE = 2'd1;
  localparam logic [CLS_BITS-1:0] CLS_LATE   = 2'd2;

  localparam int MID_DEPTH_DEFAULT = 2;
  localparam int OUT_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [TIME_BITS-1:0] photon_time;
    logic [TIME_BITS-1:0] slot_center;
    logic                 new_slot;
  } in_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  registered_time;
    logic [COUNT_BITS-1:0] registered_count;
  } out_t;

  // A classified item passed from the front end to the back end.
  typedef struct packed {
    logic [TIME_BITS-1:0] photon_time;
    logic                 new_slot;
    logic [CLS_BITS-1:0]  cls;
  } mid_t;

  localparam int MID_BITS = $bits(mid_t);
  localparam int OUT_BITS = $bits(out_t);

endpackage

`default_nettype wire

FILE: rtl/gpd_fifo.sv
// Small register queue shared by the middle and result queues.
// Depends on nothing; the payload is a plain vector of WIDTH bits.
`default_nettype none

module gpd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gpd_front.sv
// Front end: accepts photon items and places each against its slot window.
// Depends on gpd_pkg; feeds the middle queue through a register stage.
`default_nettype none

module gpd_front
  import gpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire in_t                 photon,
  output logic                     full,
  input  wire logic [CFG_BITS-1:0] gate_width,
  output logic                     mid_valid,
  output mid_t                     mid_item,
  input  wire logic                mid_full
);

  logic [TIME_BITS-1:0] diff_before;
  logic [TIME_BITS-1:0] diff_after;
  logic [CMP_BITS-1:0]  half;
  logic                 is_before;
  logic [CLS_BITS-1:0]  cls;
  logic                 accept;

  // The stage holds only while its item cannot enter the middle queue.
  assign full   = mid_valid && mid_full;
  assign accept = push && !full;

  // 2*|t - c| <= gate_width is the same as |t - c| <= floor(gate_width / 2).
  always_comb begin
    half        = CMP_BITS'(gate_width >> 1);
    is_before   = photon.photon_time < photon.slot_center;
    diff_before = photon.slot_center - photon.photon_time;
    diff_after  = photon.photon_time - photon.slot_center;
    if (is_before) begin
      cls = (CMP_BITS'(diff_before) > half) ? CLS_EARLY : CLS_INSIDE;
    end else begin
      cls = (CMP_BITS'(diff_after) > half) ? CLS_LATE : CLS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (!full) begin
      mid_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_item.photon_time <= photon.photon_time;
      mid_item.new_slot    <= photon.new_slot;
      mid_item.cls         <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gpd_back.sv
// Back end: keeps the slot, dead-time and count state and decides registrations.
// Depends on gpd_pkg; drains the middle queue and fills the result queue.
`default_nettype none

module gpd_back
  import gpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [CFG_BITS-1:0] holdoff,
  input  wire logic                mid_empty,
  input  wire mid_t                mid_item,
  output logic                     mid_pop,
  input  wire logic                out_full,
  output logic                     out_push,
  output out_t                     out_item
);

  logic [TIME_BITS-1:0]  last_registered;
  logic                  have_registered;
  logic                  slot_closed;
  logic [COUNT_BITS-1:0] reg_count;

  logic [TIME_BITS-1:0]  since_last;
  logic                  slot_open;
  logic                  dead_ok;
  logic                  hit;
  logic                  slot_closed_next;
  logic [COUNT_BITS-1:0] reg_count_next;

  assign mid_pop = !mid_empty && !out_full;

  always_comb begin
    since_last = mid_item.photon_time - last_registered;
    // A photon earlier than the last registration never passes, even with no dead time.
    dead_ok = !have_registered ||
              ((mid_item.photon_time >= last_registered) &&
               (CMP_BITS'(since_last) >= CMP_BITS'(holdoff)));
    slot_open        = mid_item.new_slot || !slot_closed;
    hit              = 1'b0;
    slot_closed_next = mid_item.new_slot ? 1'b0 : slot_closed;
    if (slot_open) begin
      case (mid_item.cls)
        CLS_LATE: begin
          slot_closed_next = 1'b1;
        end
        CLS_INSIDE: begin
          if (dead_ok) begin
            hit              = 1'b1;
            slot_closed_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    reg_count_next = (reg_count == COUNT_MAX) ? reg_count : reg_count + 1'b1;
  end

  assign out_push = mid_pop && hit;
  assign out_item.registered_time  = mid_item.photon_time;
  assign out_item.registered_count = reg_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_registered <= '0;
      have_registered <= 1'b0;
      slot_closed     <= 1'b0;
      reg_count       <= '0;
    end else if (mid_pop) begin
      slot_closed <= slot_closed_next;
      if (hit) begin
        last_registered <= mid_item.photon_time;
        have_registered <= 1'b1;
        reg_count       <= reg_count_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gated_photon_detect_dead_time.sv
// Gated single-photon detector with dead time: accepts one photon item per clock
// while not full and returns one result item for each registration. One item per cycle
// is sustained while no queue fills; a result passes the front-end register, the middle
// queue, the back end and the result queue. The back end makes a combinational dead-time
// compare to the last registered time. Depends on gpd_pkg, gpd_fifo, gpd_front and gpd_back.
`default_nettype none

module gated_photon_detect_dead_time
  import gpd_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire in_t                       photon,
  output logic                           full,
  output logic                           empty,
  input  wire logic                      pop,
  output out_t                           result,
  input  wire logic                      wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] wr_index,
  input  wire logic [CFG_BITS-1:0]       wr_data
);

  logic [CFG_BITS-1:0] gate_width;
  logic [CFG_BITS-1:0] holdoff;

  logic                mid_valid;
  mid_t                mid_in;
  logic                mid_full;
  logic                mid_empty;
  logic                mid_pop;
  logic [MID_BITS-1:0] mid_rdata;
  mid_t                mid_out;

  logic                out_push;
  out_t                out_item;
  logic                out_full;
  logic [OUT_BITS-1:0] out_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_width <= GATE_WIDTH_RESET;
      holdoff    <= DEAD_TIME_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_GATE_WIDTH: gate_width <= wr_data;
        REG_DEAD_TIME:  holdoff    <= wr_data;
        default: begin
        end
      endcase
    end
  end

  gpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .photon     (photon),
    .full       (full),
    .gate_width (gate_width),
    .mid_valid  (mid_valid),
    .mid_item   (mid_in),
    .mid_full   (mid_full)
  );

  gpd_fifo #(
    .WIDTH (MID_BITS),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_valid),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_out = mid_t'(mid_rdata);

  gpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .holdoff   (holdoff),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  gpd_fifo #(
    .WIDTH (OUT_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign result = out_t'(out_rdata);

endmodule

`default_nettype wire
